// ===== design/hrlp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, constants and character tables for the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    localparam int unsigned DEF_MAX_LINE_BYTES = 2048;
    localparam int unsigned DEF_QUEUE_DEPTH    = 4;

    localparam int unsigned GET_LEN   = 3;
    localparam int unsigned VER_LEN   = 10;
    localparam int unsigned POS_CAP   = 11;
    localparam int unsigned COUNT_CAP = 4;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    localparam logic [1:0] VER_NONE = 2'd0;
    localparam logic [1:0] VER_1_0  = 2'd1;
    localparam logic [1:0] VER_1_1  = 2'd2;

    typedef struct packed {
        logic               end_of_line;
        logic               is_space;
        logic [GET_LEN-1:0] get_hit;
        logic [VER_LEN-1:0] v10_hit;
        logic [VER_LEN-1:0] v11_hit;
    } t_item;

    typedef struct packed {
        logic        request_ok;
        logic        method_is_get;
        logic        version_known;
        logic        is_http11;
        logic [10:0] url_start;
        logic [11:0] url_length;
    } t_result;

    function automatic logic [7:0] get_char(input int unsigned pos);
        logic [7:0] c;
        case (pos)
            0:       c = 8'h47;
            1:       c = 8'h45;
            2:       c = 8'h54;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ver_char(input int unsigned pos, input logic minor);
        logic [7:0] c;
        case (pos)
            0:       c = 8'h48;
            1:       c = 8'h54;
            2:       c = 8'h54;
            3:       c = 8'h50;
            4:       c = 8'h2f;
            5:       c = 8'h31;
            6:       c = 8'h2e;
            7:       c = minor ? 8'h31 : 8'h30;
            8:       c = 8'h0d;
            9:       c = 8'h0a;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/hrlp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrlp_front
// Classifies each incoming byte: space, and its match against every position
// of the method and version strings.
// ----------------------------------------------------------------------------
module hrlp_front (
    input  wire logic [7:0]     i_line_byte,
    input  wire logic           i_end_of_line,
    output hrlp_pkg::t_item     o_item
);
    import hrlp_pkg::*;

    always_comb begin
        o_item             = '0;
        o_item.end_of_line = i_end_of_line;
        o_item.is_space    = (i_line_byte == SPACE_CHAR);
        for (int i = 0; i < GET_LEN; i++) begin
            o_item.get_hit[i] = (i_line_byte == get_char(i));
        end
        for (int i = 0; i < VER_LEN; i++) begin
            o_item.v10_hit[i] = (i_line_byte == ver_char(i, 1'b0));
            o_item.v11_hit[i] = (i_line_byte == ver_char(i, 1'b1));
        end
    end

endmodule
`default_nettype wire

// ===== design/hrlp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrlp_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module hrlp_queue #(
    parameter int unsigned DEPTH = hrlp_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  hrlp_pkg::t_item     i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output hrlp_pkg::t_item     o_item
);
    import hrlp_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== design/hrlp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrlp_back
// Token tracking and matching state, one item per cycle unless an end-of-line
// item waits for room in the two-entry result queue on the output side.
// ----------------------------------------------------------------------------
module hrlp_back #(
    parameter int unsigned MAX_LINE_BYTES = hrlp_pkg::DEF_MAX_LINE_BYTES
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  hrlp_pkg::t_item     i_item,
    output logic                o_take,
    output logic                o_empty,
    input  wire logic           i_pop,
    output hrlp_pkg::t_result   o_result
);
    import hrlp_pkg::*;

    localparam int unsigned OW = $clog2(MAX_LINE_BYTES + 1);

    logic [2:0]    r_token_count, n_token_count;
    logic          r_inside, n_inside;
    logic [3:0]    r_pos, n_pos;
    logic          r_get_still, n_get_still;
    logic          r_get_matched, n_get_matched;
    logic          r_v10_still, n_v10_still;
    logic          r_v11_still, n_v11_still;
    logic [1:0]    r_version, n_version;
    logic [OW-1:0] r_byte_offset, n_byte_offset;
    logic [10:0]   r_url_offset, n_url_offset;
    logic [11:0]   r_url_bytes, n_url_bytes;
    logic          r_overlong, n_overlong;

    t_result       res;
    logic [3:0]    get_hit_ext;
    logic [15:0]   v10_hit_ext, v11_hit_ext;

    t_result       r_res [2];
    logic          r_res_wr, r_res_rd;
    logic [1:0]    r_res_cnt, n_res_cnt;
    logic          res_room, res_wr, res_rd;

    assign res_room    = (r_res_cnt != 2'd2);
    assign o_take      = i_valid && (!i_item.end_of_line || res_room);
    assign res_wr      = o_take && i_item.end_of_line;
    assign res_rd      = i_pop && !o_empty;
    assign o_empty     = (r_res_cnt == 2'd0);
    assign o_result    = r_res[r_res_rd];
    assign get_hit_ext = {1'b0, i_item.get_hit};
    assign v10_hit_ext = {6'b0, i_item.v10_hit};
    assign v11_hit_ext = {6'b0, i_item.v11_hit};

    always_comb begin
        n_token_count = r_token_count;
        n_inside      = r_inside;
        n_pos         = r_pos;
        n_get_still   = r_get_still;
        n_get_matched = r_get_matched;
        n_v10_still   = r_v10_still;
        n_v11_still   = r_v11_still;
        n_version     = r_version;
        n_byte_offset = r_byte_offset;
        n_url_offset  = r_url_offset;
        n_url_bytes   = r_url_bytes;
        n_overlong    = r_overlong;
        res           = '0;

        if (o_take) begin
            if (r_byte_offset >= OW'(MAX_LINE_BYTES)) begin
                n_overlong = 1'b1;
            end else begin
                if (i_item.is_space) begin
                    if (n_inside) begin
                        if (n_token_count == 3'd1) begin
                            n_get_matched = n_get_still && (n_pos == 4'(GET_LEN));
                        end
                        if (n_token_count == 3'd3) begin
                            if (n_v10_still && n_pos == 4'(VER_LEN)) begin
                                n_version = VER_1_0;
                            end else if (n_v11_still && n_pos == 4'(VER_LEN)) begin
                                n_version = VER_1_1;
                            end else begin
                                n_version = VER_NONE;
                            end
                        end
                        n_inside = 1'b0;
                    end
                end else begin
                    if (!n_inside) begin
                        if (n_token_count < 3'(COUNT_CAP)) begin
                            n_token_count = n_token_count + 1'b1;
                        end
                        n_inside = 1'b1;
                        n_pos    = '0;
                        if (n_token_count == 3'd1) begin
                            n_get_still = 1'b1;
                        end
                        if (n_token_count == 3'd2) begin
                            n_url_offset = 11'(r_byte_offset);
                            n_url_bytes  = '0;
                        end
                        if (n_token_count == 3'd3) begin
                            n_v10_still = 1'b1;
                            n_v11_still = 1'b1;
                        end
                    end
                    if (n_token_count == 3'd1) begin
                        n_get_still = n_get_still && (n_pos < 4'(GET_LEN))
                                      && get_hit_ext[n_pos[1:0]];
                    end
                    if (n_token_count == 3'd2) begin
                        n_url_bytes = n_url_bytes + 1'b1;
                    end
                    if (n_token_count == 3'd3) begin
                        n_v10_still = n_v10_still && (n_pos < 4'(VER_LEN))
                                      && v10_hit_ext[n_pos];
                        n_v11_still = n_v11_still && (n_pos < 4'(VER_LEN))
                                      && v11_hit_ext[n_pos];
                    end
                    if (n_pos < 4'(POS_CAP)) begin
                        n_pos = n_pos + 1'b1;
                    end
                end
                n_byte_offset = r_byte_offset + 1'b1;
            end

            if (i_item.end_of_line) begin
                if (n_inside) begin
                    if (n_token_count == 3'd1) begin
                        n_get_matched = n_get_still && (n_pos == 4'(GET_LEN));
                    end
                    if (n_token_count == 3'd3) begin
                        if (n_v10_still && n_pos == 4'(VER_LEN)) begin
                            n_version = VER_1_0;
                        end else if (n_v11_still && n_pos == 4'(VER_LEN)) begin
                            n_version = VER_1_1;
                        end else begin
                            n_version = VER_NONE;
                        end
                    end
                end
                res.version_known = (n_version != VER_NONE);
                res.request_ok    = (n_token_count == 3'd3) && res.version_known
                                    && !n_overlong;
                res.method_is_get = n_get_matched;
                res.is_http11     = (n_version == VER_1_1);
                res.url_start     = n_url_offset;
                res.url_length    = n_url_bytes;

                n_token_count = '0;
                n_inside      = 1'b0;
                n_pos         = '0;
                n_get_still   = 1'b0;
                n_get_matched = 1'b0;
                n_v10_still   = 1'b0;
                n_v11_still   = 1'b0;
                n_version     = VER_NONE;
                n_byte_offset = '0;
                n_url_offset  = '0;
                n_url_bytes   = '0;
                n_overlong    = 1'b0;
            end
        end
    end

    always_comb begin
        n_res_cnt = r_res_cnt;
        if (res_wr && !res_rd) begin
            n_res_cnt = r_res_cnt + 1'b1;
        end else if (res_rd && !res_wr) begin
            n_res_cnt = r_res_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_count <= '0;
            r_inside      <= 1'b0;
            r_pos         <= '0;
            r_get_still   <= 1'b0;
            r_get_matched <= 1'b0;
            r_v10_still   <= 1'b0;
            r_v11_still   <= 1'b0;
            r_version     <= VER_NONE;
            r_byte_offset <= '0;
            r_url_offset  <= '0;
            r_url_bytes   <= '0;
            r_overlong    <= 1'b0;
            r_res_wr      <= 1'b0;
            r_res_rd      <= 1'b0;
            r_res_cnt     <= '0;
        end else begin
            r_token_count <= n_token_count;
            r_inside      <= n_inside;
            r_pos         <= n_pos;
            r_get_still   <= n_get_still;
            r_get_matched <= n_get_matched;
            r_v10_still   <= n_v10_still;
            r_v11_still   <= n_v11_still;
            r_version     <= n_version;
            r_byte_offset <= n_byte_offset;
            r_url_offset  <= n_url_offset;
            r_url_bytes   <= n_url_bytes;
            r_overlong    <= n_overlong;
            r_res_cnt     <= n_res_cnt;
            if (res_wr) begin
                r_res_wr <= !r_res_wr;
            end
            if (res_rd) begin
                r_res_rd <= !r_res_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_wr) begin
            r_res[r_res_wr] <= res;
        end
    end

endmodule
`default_nettype wire

// ===== design/http_request_line_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_line_parser_top
// Byte-serial HTTP request line parser with queue-style ports.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while full is low and gives one result per line;
// the final byte is registered in the item queue and its result in the
// result queue before it shows on the result ports. The classify stage feeds
// a QUEUE_DEPTH-entry item queue, and the token tracker drains it at one item
// per cycle; the tracker holds an end-of-line item only while both result
// queue entries are occupied, so full rises only when results are not being
// popped. Lines longer than MAX_LINE_BYTES are reported with request_ok low.
module http_request_line_parser_top #(
    parameter int unsigned MAX_LINE_BYTES = hrlp_pkg::DEF_MAX_LINE_BYTES,
    parameter int unsigned QUEUE_DEPTH    = hrlp_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_line_byte,
    input  wire logic        i_end_of_line,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_request_ok,
    output logic             o_method_is_get,
    output logic             o_version_known,
    output logic             o_is_http11,
    output logic [10:0]      o_url_start,
    output logic [11:0]      o_url_length
);
    import hrlp_pkg::*;

    t_item   front_item;
    t_item   q_item;
    logic    q_valid;
    logic    q_take;
    t_result result;

    hrlp_front u_front (
        .i_line_byte   (i_line_byte),
        .i_end_of_line (i_end_of_line),
        .o_item        (front_item)
    );

    hrlp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (q_take),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    hrlp_back #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_take   (q_take),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (result)
    );

    assign o_request_ok    = result.request_ok;
    assign o_method_is_get = result.method_is_get;
    assign o_version_known = result.version_known;
    assign o_is_http11     = result.is_http11;
    assign o_url_start     = result.url_start;
    assign o_url_length    = result.url_length;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HTTP request line parser.
// ----------------------------------------------------------------------------
// Request lines are queued as bytes and pushed one item per cycle while full
// is low, with random input gaps and random result-side stalls. A bit-accurate
// parser model predicts the result of every line at its final byte. Every
// popped result is compared field by field with the oldest prediction. The
// stimulus opens with hand-written lines (methods, versions, stray tokens,
// spaces, zero bytes and an overlong line). It goes on with mostly
// well-formed random lines carrying random mutations, mixed with noise
// lines. Once, the receiver holds off long enough for the parser to fill up and
// raise full.
// ----------------------------------------------------------------------------
module tb;
    import hrlp_pkg::*;

    localparam int unsigned MAX_LINE     = DEF_MAX_LINE_BYTES;
    localparam int unsigned LIMIT        = 200000;
    localparam int unsigned IDLE_PCT     = 23;
    localparam int unsigned RANDOM_BYTES = 700;
    localparam int unsigned HOLD_LEN     = 400;
    localparam int unsigned HOLD_AT      = 2350;
    localparam int unsigned CALM_FROM    = 2500;
    localparam int unsigned CALM_TO      = 2850;
    localparam int unsigned DRAIN_CYCLES = 20;

    localparam logic [7:0]  CR       = 8'h0d;
    localparam logic [7:0]  LF       = 8'h0a;
    localparam logic [23:0] GET_WORD = "GET";
    localparam logic [79:0] V10_WORD = {"HTTP/1.0", 8'h0d, 8'h0a};
    localparam logic [79:0] V11_WORD = {"HTTP/1.1", 8'h0d, 8'h0a};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_line_byte;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        push          = 1'b0;
    logic        pop           = 1'b0;
    logic [7:0]  i_line_byte   = 8'h00;
    logic        i_end_of_line = 1'b0;
    logic        full;
    logic        empty;
    logic        o_request_ok;
    logic        o_method_is_get;
    logic        o_version_known;
    logic        o_is_http11;
    logic [10:0] o_url_start;
    logic [11:0] o_url_length;

    http_request_line_parser_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_line_byte     (i_line_byte),
        .i_end_of_line   (i_end_of_line),
        .empty           (empty),
        .pop             (pop),
        .o_request_ok    (o_request_ok),
        .o_method_is_get (o_method_is_get),
        .o_version_known (o_version_known),
        .o_is_http11     (o_is_http11),
        .o_url_start     (o_url_start),
        .o_url_length    (o_url_length)
    );

    always #1 i_clk = ~i_clk;

    // parser model state
    logic [2:0]  tok_count  = 3'd0;
    logic        in_tok     = 1'b0;
    logic [3:0]  tok_pos    = 4'd0;
    logic        get_prefix = 1'b0;
    logic        get_hit    = 1'b0;
    logic        v10_prefix = 1'b0;
    logic        v11_prefix = 1'b0;
    logic [1:0]  ver_seen   = VER_NONE;
    logic [11:0] line_bytes = 12'd0;
    logic [10:0] url_off    = 11'd0;
    logic [11:0] url_len    = 12'd0;
    logic        too_long   = 1'b0;

    t_result     predicted_lines[$];
    t_result     want;
    t_line_byte  bytes_to_send[$];
    t_line_byte  next_item;
    logic [7:0]  line_buf[$];

    int unsigned bytes_in   = 0;
    int unsigned lines_sent = 0;
    int unsigned lines_out  = 0;
    int unsigned errors     = 0;
    int unsigned cycle      = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;
    bit          took_byte  = 1'b0;
    logic        calm;

    assign calm = (bytes_in >= CALM_FROM) && (bytes_in < CALM_TO);

    task automatic close_token();
        if (in_tok) begin
            if (tok_count == 3'd1)
                get_hit = get_prefix && (tok_pos == GET_LEN);
            if (tok_count == 3'd3) begin
                if (v10_prefix && tok_pos == VER_LEN)
                    ver_seen = VER_1_0;
                else if (v11_prefix && tok_pos == VER_LEN)
                    ver_seen = VER_1_1;
                else
                    ver_seen = VER_NONE;
            end
            in_tok = 1'b0;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eol);
        int unsigned gp;
        int unsigned vp;
        t_result     res;
        gp = (tok_pos < GET_LEN) ? tok_pos : 0;
        vp = (tok_pos < VER_LEN) ? tok_pos : 0;
        if (line_bytes >= MAX_LINE) begin
            too_long = 1'b1;
        end else begin
            if (b == SPACE_CHAR) begin
                close_token();
            end else begin
                if (!in_tok) begin
                    if (tok_count < COUNT_CAP)
                        tok_count = tok_count + 3'd1;
                    in_tok  = 1'b1;
                    tok_pos = 4'd0;
                    gp      = 0;
                    vp      = 0;
                    if (tok_count == 3'd1)
                        get_prefix = 1'b1;
                    if (tok_count == 3'd2) begin
                        url_off = line_bytes[10:0];
                        url_len = 12'd0;
                    end
                    if (tok_count == 3'd3) begin
                        v10_prefix = 1'b1;
                        v11_prefix = 1'b1;
                    end
                end
                if (tok_count == 3'd1)
                    get_prefix = get_prefix && (tok_pos < GET_LEN)
                                 && (b == GET_WORD[8*(GET_LEN-1-gp) +: 8]);
                if (tok_count == 3'd2)
                    url_len = url_len + 12'd1;
                if (tok_count == 3'd3) begin
                    v10_prefix = v10_prefix && (tok_pos < VER_LEN)
                                 && (b == V10_WORD[8*(VER_LEN-1-vp) +: 8]);
                    v11_prefix = v11_prefix && (tok_pos < VER_LEN)
                                 && (b == V11_WORD[8*(VER_LEN-1-vp) +: 8]);
                end
                if (tok_pos < POS_CAP)
                    tok_pos = tok_pos + 4'd1;
            end
            line_bytes = line_bytes + 12'd1;
        end
        if (eol) begin
            close_token();
            res.request_ok    = (tok_count == 3'd3) && (ver_seen != VER_NONE) && !too_long;
            res.method_is_get = get_hit;
            res.version_known = (ver_seen != VER_NONE);
            res.is_http11     = (ver_seen == VER_1_1);
            res.url_start     = url_off;
            res.url_length    = url_len;
            predicted_lines.push_back(res);
            tok_count  = 3'd0;
            in_tok     = 1'b0;
            tok_pos    = 4'd0;
            get_prefix = 1'b0;
            get_hit    = 1'b0;
            v10_prefix = 1'b0;
            v11_prefix = 1'b0;
            ver_seen   = VER_NONE;
            line_bytes = 12'd0;
            url_off    = 11'd0;
            url_len    = 12'd0;
            too_long   = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // line building
    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        c = 8'($urandom_range(254));
        if (c >= SPACE_CHAR)
            c = c + 8'd1;
        return c;
    endfunction

    function automatic int unsigned gap_len();
        return ($urandom_range(3) == 0) ? $urandom_range(3, 2) : 1;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        line_buf.push_back(b);
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic put_spaces(input int unsigned n);
        repeat (n) line_buf.push_back(SPACE_CHAR);
    endtask

    task automatic put_token(input int unsigned n);
        repeat (n) line_buf.push_back(rand_char());
    endtask

    task automatic put_version(input string tag);
        put_text("HTTP/");
        put_text(tag);
        put_byte(CR);
        put_byte(LF);
    endtask

    task automatic commit_line();
        int         i;
        t_line_byte item;
        for (i = 0; i < line_buf.size(); i++) begin
            item.data = line_buf[i];
            item.last = (i == line_buf.size() - 1);
            bytes_to_send.push_back(item);
        end
        if (line_buf.size() != 0)
            lines_sent++;
        line_buf.delete();
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || took_byte) begin
            if (bytes_to_send.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                next_item = bytes_to_send.pop_front();
                i_line_byte   <= next_item.data;
                i_end_of_line <= next_item.last;
                push          <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left != 0) begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_in >= HOLD_AT) begin
            pop       <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else begin
            pop <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            took_byte = 1'b0;
        end else begin
            if (pop && !empty) begin
                if (predicted_lines.size() == 0) begin
                    $error("result popped with no line outstanding");
                    errors++;
                end else begin
                    want = predicted_lines.pop_front();
                    check_field("request_ok", want.request_ok, o_request_ok);
                    check_field("method_is_get", want.method_is_get, o_method_is_get);
                    check_field("version_known", want.version_known, o_version_known);
                    check_field("is_http11", want.is_http11, o_is_http11);
                    check_field("url_start", want.url_start, o_url_start);
                    check_field("url_length", want.url_length, o_url_length);
                end
                lines_out++;
            end
            took_byte = push && !full;
            if (took_byte) begin
                parse_byte(i_line_byte, i_end_of_line);
                bytes_in++;
            end
        end
    end

    initial begin
        while (cycle < LIMIT) begin
            @(posedge i_clk);
            cycle++;
        end
        $display("tb: errors");
        $finish;
    end

    initial begin
        int unsigned random_bytes;
        int unsigned ms;
        int unsigned vs;
        random_bytes = 0;

        // directed lines
        put_text("GET /index.html ");
        put_version("1.1");
        commit_line();
        put_text("  POST /form?a=1   ");
        put_version("1.0");
        put_spaces(2);
        commit_line();
        put_text("GET / ");
        put_version("1.1");
        put_text(" extra tokens");
        commit_line();
        put_text("GET /a ");
        put_version("2.0");
        commit_line();
        put_text("GETX /b ");
        put_version("1.0");
        commit_line();
        put_text("GE /c ");
        put_version("1.1");
        commit_line();
        put_text("get /d ");
        put_version("1.1");
        commit_line();
        put_text("GET /e HTTP/1.1");
        commit_line();
        put_byte(8'h00);
        commit_line();
        put_spaces(1);
        commit_line();
        put_text("GET");
        commit_line();
        put_text("GET /only");
        commit_line();
        put_text("GET /");
        put_byte(8'hff);
        put_byte(8'h00);
        put_byte(8'h80);
        put_byte(8'h7f);
        put_byte(CR);
        put_spaces(1);
        put_version("1.0");
        commit_line();
        // overlong, url token on the last counted byte
        put_text("GET");
        put_spaces(MAX_LINE - 4);
        put_text("/overflow ");
        put_version("1.1");
        commit_line();

        // random lines
        while (random_bytes < RANDOM_BYTES) begin
            if ($urandom_range(99) < 78) begin
                if ($urandom_range(9) == 0)
                    put_spaces($urandom_range(3, 1));
                ms = line_buf.size();
                case ($urandom_range(9))
                    0: put_text("GE");
                    1: put_text("GETT");
                    2: put_token($urandom_range(6, 1));
                    3: begin
                        put_text("GET");
                        line_buf[ms + $urandom_range(2)] = rand_char();
                    end
                    default: put_text("GET");
                endcase
                if ($urandom_range(19) != 0) begin
                    put_spaces(gap_len());
                    put_text("/");
                    put_token($urandom_range(30));
                    if ($urandom_range(19) != 0) begin
                        put_spaces(gap_len());
                        vs = line_buf.size();
                        put_version($urandom_range(1) ? "1.1" : "1.0");
                        case ($urandom_range(9))
                            0: line_buf[vs + $urandom_range(9)] = rand_char();
                            1: repeat ($urandom_range(3, 1)) void'(line_buf.pop_back());
                            2: put_byte(rand_char());
                            default: ;
                        endcase
                        if ($urandom_range(9) == 0) begin
                            put_spaces(gap_len());
                            put_token($urandom_range(8, 1));
                        end
                    end
                end
                if ($urandom_range(9) == 0)
                    put_spaces($urandom_range(3, 1));
            end else begin
                repeat ($urandom_range(30, 1))
                    put_byte(($urandom_range(9) < 3) ? SPACE_CHAR : rand_char());
            end
            random_bytes += line_buf.size();
            commit_line();
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (bytes_to_send.size() != 0 || push)
            @(posedge i_clk);
        while (predicted_lines.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("pushed %0d bytes in %0d lines (%0d random bytes), checked %0d results",
                 bytes_in, lines_sent, random_bytes, lines_out);
        $display("covered an overlong line and a %0d-cycle result stall", HOLD_LEN);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
